// ===== design/sks_pkg.sv =====
// Shared request and status codes for the sorted key set.
package sks_pkg;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    localparam t_req REQ_FIND   = 2'd0;
    localparam t_req REQ_ADD    = 2'd1;
    localparam t_req REQ_REMOVE = 2'd2;

    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_NOP  = 2'd1;
    localparam t_status ST_FULL = 2'd2;

    localparam int KEY_W   = 32;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

endpackage

// ===== design/sorted_key_set_top.sv =====
// Sorted key set: ascending set of unique 32-bit keys in one synchronous memory.
//
// Usage:
//   A request (i_req_type, i_key) is a transfer at a rising edge where start
//   is high and busy is low. busy stays high until the cycle that carries
//   the result. Every request yields exactly one result: o_valid is high for
//   one cycle with o_found, o_position, o_entry_count and o_status. The
//   receiver cannot hold a result off; it must take it in that cycle.
// Flow, with n keys held:
//   binary search: each probe reads the key at mid (S_SRCH) and narrows
//   the window (S_CMP); S_CHECK compares the key at the bound if below n.
//   add that inserts: search, then n - pos entries move up, one entry moved
//   per cycle, then the key is written; remove of a present key: search,
//   then n - pos - 1 entries move down, one entry per cycle. The single read
//   port of the key memory sets this pace. busy is low while o_valid is high,
//   so the next request can transfer at the edge that ends that cycle.
// Reset (synchronous, active low) empties the set; memory contents are not
// cleared, since entries at or above the count are never used.
// position and entry_count wrap to 8 and 9 bits for large capacities.
module sorted_key_set_top
    import sks_pkg::*;
#(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_req_type,
    input  logic [KEY_W-1:0]   i_key,
    output logic               busy,
    output logic               o_valid,
    output logic               o_found,
    output logic [POS_W-1:0]   o_position,
    output logic [COUNT_W-1:0] o_entry_count,
    output logic [1:0]         o_status
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;  // issue probe read or end search
    localparam logic [3:0] S_CMP    = 4'd2;  // narrow the search window
    localparam logic [3:0] S_CHECK  = 4'd3;  // compare key at lower bound
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_UP     = 4'd5;  // move entries up for insert
    localparam logic [3:0] S_INS    = 4'd6;
    localparam logic [3:0] S_DN     = 4'd7;  // move entries down for remove

    logic [3:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_done,  n_done;

    t_req             r_req,    n_req;
    logic [KEY_W-1:0] r_key,    n_key;
    logic [CW-1:0]    r_lo,     n_lo;
    logic [CW-1:0]    r_hi,     n_hi;
    logic [CW-1:0]    r_ptr,    n_ptr;
    logic             r_found,  n_found;
    t_status          r_status, n_status;

    // key memory, one write and one registered read per cycle
    logic [KEY_W-1:0] r_mem [CAPACITY];
    logic [KEY_W-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_wdata;

    logic [CW-1:0]    mid;
    logic             pos_en;
    logic [CW+POS_W-1:0]   pos_ext;
    logic [CW+COUNT_W-1:0] cnt_ext;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign mid = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_done    = 1'b0;
        n_req     = r_req;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_ptr     = r_ptr;
        n_found   = r_found;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_ptr[AW-1:0];
        mem_wdata = r_rdata;
        mem_raddr = mid[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req_type;
                    n_key   = i_key;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    mem_raddr = mid[AW-1:0];
                    n_ptr     = mid;
                    n_state   = S_CMP;
                end else if (r_lo < r_count) begin
                    mem_raddr = r_lo[AW-1:0];
                    n_state   = S_CHECK;
                end else begin
                    n_found = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_CMP: begin
                if (r_rdata < r_key) begin
                    n_lo = r_ptr + CW'(1);
                end else begin
                    n_hi = r_ptr;
                end
                n_state = S_SRCH;
            end
            S_CHECK: begin
                n_found = (r_rdata == r_key);
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_status = ST_DONE;
                case (r_req)
                    REQ_ADD: begin
                        if (r_found) begin
                            n_status = ST_NOP;
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                        end else if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                        end else if (r_count > r_lo) begin
                            mem_raddr = AW'(r_count - CW'(1));
                            n_ptr     = r_count;
                            n_state   = S_UP;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!r_found) begin
                            n_status = ST_NOP;
                            n_state  = S_IDLE;
                            n_done   = 1'b1;
                        end else if (r_lo + CW'(1) < r_count) begin
                            mem_raddr = AW'(r_lo + CW'(1));
                            n_ptr     = r_lo;
                            n_state   = S_DN;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_IDLE;
                            n_done  = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                endcase
            end
            S_UP: begin
                // write entry ptr from ptr-1 while fetching ptr-2
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = r_rdata;
                if (r_ptr - CW'(1) > r_lo) begin
                    mem_raddr = AW'(r_ptr - CW'(2));
                    n_ptr     = r_ptr - CW'(1);
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo[AW-1:0];
                mem_wdata = r_key;
                n_count   = r_count + CW'(1);
                n_state   = S_IDLE;
                n_done    = 1'b1;
            end
            S_DN: begin
                // write entry ptr from ptr+1 while fetching ptr+2
                mem_we    = 1'b1;
                mem_waddr = r_ptr[AW-1:0];
                mem_wdata = r_rdata;
                if (r_ptr + CW'(2) < r_count) begin
                    mem_raddr = AW'(r_ptr + CW'(2));
                    n_ptr     = r_ptr + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_ptr    <= n_ptr;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // position reported for a hit or a fresh insert, else zero
    assign pos_en  = r_found || ((r_req == REQ_ADD) && (r_status == ST_DONE));
    assign pos_ext = {{POS_W{1'b0}}, (pos_en ? r_lo : CW'(0))};
    assign cnt_ext = {{COUNT_W{1'b0}}, r_count};

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_done;
    assign o_found       = r_found;
    assign o_position    = pos_ext[POS_W-1:0];
    assign o_entry_count = cnt_ext[COUNT_W-1:0];
    assign o_status      = r_status;

endmodule
